// ===== src/npcs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and codes for the nearest palette colour search block.
package npcs_pkg;

    localparam int PALETTE_ENTRIES_DEF = 256;
    localparam int COLOR_W             = 8;
    localparam int IDX_W               = 8;
    localparam int ENTRY_W             = 3 * COLOR_W;
    localparam int SQ_W                = 2 * COLOR_W;
    localparam int DIST_W              = 18;
    localparam int DIST_MAX            = 195075;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN
    } t_state;

    // Marks one palette read travelling towards the distance unit.
    typedef struct packed {
        logic             vld;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    function automatic logic [COLOR_W-1:0] abs_diff(
        input logic [COLOR_W-1:0] a,
        input logic [COLOR_W-1:0] b
    );
        logic [COLOR_W-1:0] d;
        d = (a >= b) ? (a - b) : (b - a);
        return d;
    endfunction

endpackage

// ===== src/npcs_palette_mem.sv =====
`timescale 1ns / 1ps
// Palette store: one write port, one registered read port, per-entry written flags.
module npcs_palette_mem #(
    parameter int DEPTH = npcs_pkg::PALETTE_ENTRIES_DEF,
    parameter int AW    = $clog2(npcs_pkg::PALETTE_ENTRIES_DEF)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [AW-1:0]                i_wr_addr,
    input  logic [npcs_pkg::ENTRY_W-1:0] i_wr_data,
    input  logic                         i_rd_en,
    input  logic [AW-1:0]                i_rd_addr,
    output logic [npcs_pkg::ENTRY_W-1:0] o_rd_data
);

    logic [npcs_pkg::ENTRY_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]             r_written;
    logic [npcs_pkg::ENTRY_W-1:0] r_rd_data;
    logic                         r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // Entries never written read as black.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_written[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_written <= r_written[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : '0;

endmodule

// ===== src/npcs_seq.sv =====
`timescale 1ns / 1ps
// Query sequencer: walks the palette addresses and tags each read.
module npcs_seq #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_query,
    input  logic                                    i_fin,
    output logic                                    o_busy,
    output logic                                    o_rd_en,
    output logic [$clog2(PALETTE_ENTRIES)-1:0]      o_rd_addr,
    output npcs_pkg::t_tag                          o_tag
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int IW = npcs_pkg::IDX_W;

    npcs_pkg::t_state r_state, n_state;
    logic [AW-1:0]    r_addr, n_addr;
    npcs_pkg::t_tag   r_tag, n_tag;
    logic             rd_en;
    logic             last_addr;

    assign last_addr = (r_addr == AW'(PALETTE_ENTRIES - 1));

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_tag   = '0;
        rd_en   = 1'b0;
        case (r_state)
            npcs_pkg::ST_IDLE: begin
                if (i_query) begin
                    n_state = npcs_pkg::ST_SWEEP;
                    n_addr  = '0;
                end
            end
            npcs_pkg::ST_SWEEP: begin
                rd_en     = 1'b1;
                n_tag.vld = 1'b1;
                n_tag.idx = IW'(r_addr);
                n_tag.last = last_addr;
                if (last_addr) begin
                    n_state = npcs_pkg::ST_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            npcs_pkg::ST_DRAIN: begin
                if (i_fin) begin
                    n_state = npcs_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = npcs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcs_pkg::ST_IDLE;
            r_tag   <= '0;
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    assign o_busy    = (r_state != npcs_pkg::ST_IDLE);
    assign o_rd_en   = rd_en;
    assign o_rd_addr = r_addr;
    assign o_tag     = r_tag;

endmodule

// ===== src/npcs_dist_unit.sv =====
`timescale 1ns / 1ps
// Shared distance unit: squares, sums and keeps the running nearest entry.
module npcs_dist_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_query,
    input  logic [npcs_pkg::COLOR_W-1:0] i_red,
    input  logic [npcs_pkg::COLOR_W-1:0] i_green,
    input  logic [npcs_pkg::COLOR_W-1:0] i_blue,
    input  logic [npcs_pkg::ENTRY_W-1:0] i_entry,
    input  npcs_pkg::t_tag               i_tag,
    output logic                         o_fin,
    output logic                         o_valid,
    output logic [npcs_pkg::IDX_W-1:0]   o_nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]  o_nearest_distance
);

    localparam int CW = npcs_pkg::COLOR_W;
    localparam int SW = npcs_pkg::SQ_W;
    localparam int DW = npcs_pkg::DIST_W;

    logic [CW-1:0]  r_qr, r_qg, r_qb;
    logic [CW-1:0]  dr, dg, db;
    logic [SW-1:0]  r_sq_r, r_sq_g, r_sq_b;
    npcs_pkg::t_tag r_s2;
    logic [DW-1:0]  cand_dist;
    logic           better;
    logic [DW-1:0]  r_best_dist, n_best_dist;
    logic [npcs_pkg::IDX_W-1:0] r_best_idx, n_best_idx;
    logic           r_valid;
    logic [npcs_pkg::IDX_W-1:0] r_out_idx;
    logic [DW-1:0]  r_out_dist;

    // Stage one: per-channel squared differences.
    assign dr = npcs_pkg::abs_diff(r_qr, i_entry[3*CW-1:2*CW]);
    assign dg = npcs_pkg::abs_diff(r_qg, i_entry[2*CW-1:CW]);
    assign db = npcs_pkg::abs_diff(r_qb, i_entry[CW-1:0]);

    always_ff @(posedge i_clk) begin
        if (i_query) begin
            r_qr <= i_red;
            r_qg <= i_green;
            r_qb <= i_blue;
        end
        r_sq_r <= SW'(dr) * SW'(dr);
        r_sq_g <= SW'(dg) * SW'(dg);
        r_sq_b <= SW'(db) * SW'(db);
    end

    // Stage two: sum and strict compare, so the lowest index keeps a tie.
    assign cand_dist = DW'(r_sq_r) + DW'(r_sq_g) + DW'(r_sq_b);
    assign better    = r_s2.vld && (cand_dist < r_best_dist);
    assign o_fin     = r_s2.vld && r_s2.last;

    always_comb begin
        n_best_dist = r_best_dist;
        n_best_idx  = r_best_idx;
        if (better) begin
            n_best_dist = cand_dist;
            n_best_idx  = r_s2.idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_s2    <= i_tag;
            r_valid <= o_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_query) begin
            r_best_dist <= '1;
            r_best_idx  <= '0;
        end else begin
            r_best_dist <= n_best_dist;
            r_best_idx  <= n_best_idx;
        end
        if (o_fin) begin
            r_out_idx  <= n_best_idx;
            r_out_dist <= n_best_dist;
        end
    end

    assign o_valid            = r_valid;
    assign o_nearest_index    = r_out_idx;
    assign o_nearest_distance = r_out_dist;

endmodule

// ===== src/nearest_palette_color_search_top.sv =====
`timescale 1ns / 1ps
// Top level of the nearest palette colour search block.
// A beat is accepted when start is high and busy is low. A write beat (req_type 0)
// loads one palette entry in that same cycle, gives no result and leaves busy low,
// so writes can follow each other every cycle; a write to an index at or above
// PALETTE_ENTRIES is dropped. A query beat (req_type 1) raises busy and walks the
// palette one entry per cycle through a single shared distance unit, fed by the
// one read port of the palette memory. The result beat (o_valid for exactly one
// cycle) arrives after the whole sweep, once the last entry has passed the memory
// read, the squaring stage and the compare stage, each registered in turn. busy
// falls in the cycle that o_valid is shown, so the next beat may be accepted then.
// The receiver cannot stall: o_nearest_index and o_nearest_distance are valid only
// while o_valid is high. Entries never written read as black, and on equal
// distances the lowest index wins.
module nearest_palette_color_search_top #(
    parameter int PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_req_type,
    input  logic [npcs_pkg::IDX_W-1:0]    i_entry_index,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_red,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_green,
    input  logic [npcs_pkg::COLOR_W-1:0]  i_blue,
    output logic                          o_valid,
    output logic [npcs_pkg::IDX_W-1:0]    o_nearest_index,
    output logic [npcs_pkg::DIST_W-1:0]   o_nearest_distance
);

    localparam int AW = $clog2(PALETTE_ENTRIES);
    localparam int XW = npcs_pkg::IDX_W + 1;

    logic                         accept;
    logic                         in_range;
    logic                         wr_en;
    logic                         query;
    logic                         fin;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [npcs_pkg::ENTRY_W-1:0] rd_data;
    npcs_pkg::t_tag               tag;

    // Take a beat only while no query is in flight.
    assign accept   = start && !busy;
    assign in_range = ({1'b0, i_entry_index} < XW'(PALETTE_ENTRIES));
    // Drop writes beyond the palette; they never reach the store.
    assign wr_en    = accept && (i_req_type == npcs_pkg::REQ_WRITE) && in_range;
    assign query    = accept && (i_req_type == npcs_pkg::REQ_QUERY);

    npcs_palette_mem #(
        .DEPTH (PALETTE_ENTRIES),
        .AW    (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_entry_index[AW-1:0]),
        .i_wr_data ({i_red, i_green, i_blue}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // Advance one palette address per cycle during a query.
    npcs_seq #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_query   (query),
        .i_fin     (fin),
        .o_busy    (busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_tag     (tag)
    );

    // Hold the query colour and the running best; emit one result beat.
    npcs_dist_unit u_dist (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_query            (query),
        .i_red              (i_red),
        .i_green            (i_green),
        .i_blue             (i_blue),
        .i_entry            (rd_data),
        .i_tag              (tag),
        .o_fin              (fin),
        .o_valid            (o_valid),
        .o_nearest_index    (o_nearest_index),
        .o_nearest_distance (o_nearest_distance)
    );

    // A result beat is only shown once the sweep has released the block.
    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat shown while busy");

    // An accepted query must occupy the block on the next cycle.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == npcs_pkg::REQ_QUERY) |=> busy)
        else $error("query accepted but block not busy");

    // A write never raises busy.
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_req_type == npcs_pkg::REQ_WRITE) |=> !busy)
        else $error("write beat made the block busy");

    // One query gives one result beat, never two in a row.
    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat repeated");

    // The reported distance stays within the RGB cube diagonal squared.
    a_dist_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_nearest_distance <= npcs_pkg::DIST_W'(npcs_pkg::DIST_MAX)))
        else $error("nearest distance out of range");

endmodule

// ===== tb/nearest_palette_color_search_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the nearest palette colour search block.
module nearest_palette_color_search_top_test;
    import npcs_pkg::*;

    localparam int NUM_ENTRIES   = PALETTE_ENTRIES_DEF;
    localparam int RAND_ITEMS    = 1430;
    // Wait out a full palette sweep and the result beat of the last query, with slack.
    localparam int SETTLE_CYCLES = NUM_ENTRIES + 8;
    // Slowest correct run: every beat a query, each a full palette sweep, plus sender
    // gaps between beats. The limit takes that several times over.
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int DIR_ROWS      = 24;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [IDX_W-1:0]  index;
        logic [DIST_W-1:0] distance;
    } t_nearest;

    // One stimulus beat; known marks a row whose result is typed in by hand.
    typedef struct packed {
        logic               req;
        logic [IDX_W-1:0]   entry;
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               known;
        logic [IDX_W-1:0]   want_idx;
        logic [DIST_W-1:0]  want_dist;
    } t_beat;

    // Directed rows: untouched palette, extremes, ties, ignored entry index on queries.
    t_beat dir_beats [DIR_ROWS] = '{
        // all-black palette: exact hit, furthest colour, small offset
        '{REQ_QUERY, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   18'd0},
        '{REQ_QUERY, 8'hFF, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   18'd195075},
        '{REQ_QUERY, 8'h55, 8'd1,   8'd2,   8'd3,   1'b1, 8'd0,   18'd14},
        // white in the top entry
        '{REQ_WRITE, 8'hFF, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0,   18'd0},
        '{REQ_QUERY, 8'hAA, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 18'd0},
        '{REQ_QUERY, 8'h00, 8'd250, 8'd251, 8'd252, 1'b1, 8'd255, 18'd50},
        // red in entry 0: black now first found at entry 1
        '{REQ_WRITE, 8'h00, 8'd255, 8'd0,   8'd0,   1'b0, 8'd0,   18'd0},
        '{REQ_QUERY, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd1,   18'd0},
        '{REQ_WRITE, 8'h01, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0,   18'd0},
        '{REQ_QUERY, 8'hFF, 8'd0,   8'd0,   8'd0,   1'b1, 8'd2,   18'd0},
        // same colour twice: lower index must win the tie
        '{REQ_WRITE, 8'd128, 8'd10, 8'd20,  8'd30,  1'b0, 8'd0,   18'd0},
        '{REQ_WRITE, 8'd200, 8'd10, 8'd20,  8'd30,  1'b0, 8'd0,   18'd0},
        '{REQ_QUERY, 8'd200, 8'd12, 8'd18,  8'd33,  1'b1, 8'd128, 18'd17},
        '{REQ_QUERY, 8'd201, 8'd10, 8'd20,  8'd30,  1'b1, 8'd128, 18'd0},
        // alternating bit patterns
        '{REQ_WRITE, 8'd100, 8'h55, 8'hAA,  8'h55,  1'b0, 8'd0,   18'd0},
        '{REQ_WRITE, 8'd101, 8'hAA, 8'h55,  8'hAA,  1'b0, 8'd0,   18'd0},
        '{REQ_QUERY, 8'h5A,  8'hAA, 8'h55,  8'hAA,  1'b1, 8'd101, 18'd0},
        '{REQ_QUERY, 8'hA5,  8'h55, 8'hAA,  8'h56,  1'b1, 8'd100, 18'd1},
        '{REQ_QUERY, 8'h00,  8'd255, 8'd0,  8'd0,   1'b1, 8'd0,   18'd0},
        '{REQ_QUERY, 8'h00,  8'd0,  8'd255, 8'd1,   1'b1, 8'd1,   18'd1},
        '{REQ_WRITE, 8'h02,  8'd128, 8'd128, 8'd128, 1'b0, 8'd0,  18'd0},
        '{REQ_QUERY, 8'h00,  8'd0,  8'd0,   8'd0,   1'b1, 8'd3,   18'd0},
        // left to the predictor
        '{REQ_QUERY, 8'h11,  8'd128, 8'd127, 8'd129, 1'b0, 8'd0,  18'd0},
        '{REQ_QUERY, 8'h22,  8'd0,  8'd128, 8'd255, 1'b0, 8'd0,   18'd0}
    };

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                start         = 1'b0;
    logic                i_req_type    = REQ_WRITE;
    logic [IDX_W-1:0]    i_entry_index = '0;
    logic [COLOR_W-1:0]  i_red         = '0;
    logic [COLOR_W-1:0]  i_green       = '0;
    logic [COLOR_W-1:0]  i_blue        = '0;
    logic                busy;
    logic                o_valid;
    logic [IDX_W-1:0]    o_nearest_index;
    logic [DIST_W-1:0]   o_nearest_distance;

    // Own copy of the palette, as the block should hold it after each accepted beat.
    t_rgb        palette_copy [NUM_ENTRIES];
    t_nearest    nearest_expected_q [$];
    int          err_count   = 0;
    int          beats_sent  = 0;
    int          idle_pct    = 0;
    int unsigned cycle_count = 0;
    int          idle_plan [4] = '{0, 68, 31, 0};

    always #10 i_clk = ~i_clk;

    nearest_palette_color_search_top #(
        .PALETTE_ENTRIES(NUM_ENTRIES)
    ) u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_req_type        (i_req_type),
        .i_entry_index     (i_entry_index),
        .i_red             (i_red),
        .i_green           (i_green),
        .i_blue            (i_blue),
        .o_valid           (o_valid),
        .o_nearest_index   (o_nearest_index),
        .o_nearest_distance(o_nearest_distance)
    );

    // Sweep the palette copy in ascending order; replace the best only on a strictly
    // smaller squared distance, so the lowest index keeps a tie.
    function automatic t_nearest find_nearest(t_rgb q);
        t_nearest best;
        int       best_d;
        int       dr;
        int       dg;
        int       db;
        int       d;
        best   = '0;
        best_d = 32'h7FFF_FFFF;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            dr = int'(q.red)   - int'(palette_copy[i].red);
            dg = int'(q.green) - int'(palette_copy[i].green);
            db = int'(q.blue)  - int'(palette_copy[i].blue);
            d  = dr * dr + dg * dg + db * db;
            if (d < best_d) begin
                best_d     = d;
                best.index = i[IDX_W-1:0];
            end
        end
        best.distance = best_d[DIST_W-1:0];
        return best;
    endfunction

    function automatic t_rgb rand_rgb();
        t_rgb c;
        c.red   = COLOR_W'($urandom_range(255));
        c.green = COLOR_W'($urandom_range(255));
        c.blue  = COLOR_W'($urandom_range(255));
        return c;
    endfunction

    // Nudge a component by up to three either way, clamped to the colour range.
    function automatic logic [COLOR_W-1:0] nudge(logic [COLOR_W-1:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return v[COLOR_W-1:0];
    endfunction

    function automatic t_beat mk_write(logic [IDX_W-1:0] idx, t_rgb c);
        t_beat b;
        b       = '0;
        b.req   = REQ_WRITE;
        b.entry = idx;
        b.red   = c.red;
        b.green = c.green;
        b.blue  = c.blue;
        return b;
    endfunction

    // Entry index is meaningless on a query: fill it with noise.
    function automatic t_beat mk_query(t_rgb c);
        t_beat b;
        b       = '0;
        b.req   = REQ_QUERY;
        b.entry = IDX_W'($urandom_range(255));
        b.red   = c.red;
        b.green = c.green;
        b.blue  = c.blue;
        return b;
    endfunction

    // Present one beat, hold it until accepted, then update the palette copy or log
    // the expected result, and idle the sender at the phase's rate.
    task automatic apply_beat(t_beat b);
        t_rgb c;
        c             = '{b.red, b.green, b.blue};
        start         <= 1'b1;
        i_req_type    <= b.req;
        i_entry_index <= b.entry;
        i_red         <= b.red;
        i_green       <= b.green;
        i_blue        <= b.blue;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        beats_sent++;
        if (b.req == REQ_WRITE) begin
            if (b.entry < NUM_ENTRIES)
                palette_copy[b.entry] = c;
        end else if (b.known) begin
            nearest_expected_q.push_back('{b.want_idx, b.want_dist});
        end else begin
            nearest_expected_q.push_back(find_nearest(c));
        end
        // While idle, drop start and scramble the payload so stale fields never count.
        while ($urandom_range(99) < idle_pct) begin
            start         <= 1'b0;
            i_req_type    <= 1'($urandom_range(1));
            i_entry_index <= IDX_W'($urandom_range(255));
            i_red         <= COLOR_W'($urandom_range(255));
            i_green       <= COLOR_W'($urandom_range(255));
            i_blue        <= COLOR_W'($urandom_range(255));
            @(posedge i_clk);
        end
    endtask

    // Hold the sender off until every query in flight has reported.
    task automatic drain_results();
        start <= 1'b0;
        while (nearest_expected_q.size() != 0)
            @(posedge i_clk);
    endtask

    // One random stretch of traffic: writes followed by random queries, queries that land
    // on or near palette content, ties, extremes and plain noise queries.
    task automatic random_burst();
        t_rgb c;
        int   kind;
        int   n;
        int   k;
        int   j;
        kind = $urandom_range(99);
        if (kind < 40) begin
            n = $urandom_range(6, 1);
            repeat (n) apply_beat(mk_write(IDX_W'($urandom_range(255)), rand_rgb()));
            n = $urandom_range(3, 1);
            repeat (n) apply_beat(mk_query(rand_rgb()));
        end else if (kind < 65) begin
            k = $urandom_range(NUM_ENTRIES - 1);
            c = palette_copy[k];
            c = '{nudge(c.red), nudge(c.green), nudge(c.blue)};
            apply_beat(mk_query(c));
        end else if (kind < 75) begin
            // copy an entry elsewhere so two indexes sit at the same distance
            k = $urandom_range(NUM_ENTRIES - 1);
            j = $urandom_range(NUM_ENTRIES - 1);
            c = palette_copy[k];
            apply_beat(mk_write(j[IDX_W-1:0], c));
            apply_beat(mk_query(c));
        end else if (kind < 85) begin
            c.red   = $urandom_range(1) ? 8'hFF : 8'h00;
            c.green = $urandom_range(1) ? 8'hFF : 8'h00;
            c.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
            if ($urandom_range(1))
                apply_beat(mk_write(IDX_W'($urandom_range(255)), c));
            else
                apply_beat(mk_query(c));
        end else begin
            n = $urandom_range(4, 1);
            repeat (n) apply_beat(mk_query(rand_rgb()));
        end
    endtask

    // Compare every result beat with the oldest outstanding query.
    always @(posedge i_clk) begin
        t_nearest want;
        if (i_rst_n && o_valid !== 1'b0) begin
            if (nearest_expected_q.size() == 0) begin
                err_count++;
                $display("%0t: result beat with no query pending: expected none, got index %0d distance %0d",
                         $time, o_nearest_index, o_nearest_distance);
            end else begin
                want = nearest_expected_q.pop_front();
                if (o_nearest_index !== want.index) begin
                    err_count++;
                    $display("%0t: nearest_index expected %0d, got %0d",
                             $time, want.index, o_nearest_index);
                end
                if (o_nearest_distance !== want.distance) begin
                    err_count++;
                    $display("%0t: nearest_distance expected %0d, got %0d",
                             $time, want.distance, o_nearest_distance);
                end
            end
        end
    end

    // Watchdog: abandon the run if it hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("nearest_palette_color_search_top_test: errors");
            $finish;
        end
    end

    initial begin
        int phase_end;
        foreach (palette_copy[i])
            palette_copy[i] = '0;

        // Hold reset, then release it on an edge.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed rows back to back, writes in consecutive cycles.
        idle_pct = 0;
        foreach (dir_beats[r])
            apply_beat(dir_beats[r]);
        drain_results();

        for (int p = 0; p < 4; p++) begin
            idle_pct  = idle_plan[p];
            phase_end = beats_sent + RAND_ITEMS / 4;
            // Fill the whole palette first so later searches run over varied content.
            if (p == 0) begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    apply_beat(mk_write(i[IDX_W-1:0], rand_rgb()));
            end
            while (beats_sent < phase_end)
                random_burst();
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_count == 0 && nearest_expected_q.size() == 0) begin
            $display("nearest_palette_color_search_top_test: clean");
        end else begin
            $display("nearest_palette_color_search_top_test: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/npcs_pkg.sv
src/npcs_palette_mem.sv
src/npcs_seq.sv
src/npcs_dist_unit.sv
src/nearest_palette_color_search_top.sv
tb/nearest_palette_color_search_top_test.sv
